FILE: rtl/core/cidwl_pkg.sv
// Shared constants, codes and types for the card identifier whitelist table.
`timescale 1ns / 1ps

package cidwl_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int ID_W       = 32;
    localparam int FUNC_W     = 2;
    localparam int STAT_W     = 2;
    localparam int IDX_OUT_W  = 5;

    localparam logic [ID_W-1:0] EMPTY_ID = '1;

    localparam logic [FUNC_W-1:0] OP_VERIFY = 2'd0;
    localparam logic [FUNC_W-1:0] OP_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] OP_DELETE = 2'd2;
    localparam logic [FUNC_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_MEM  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_CARD = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_RESP
    } state_t;

    // Running result of one table scan
    typedef struct packed {
        logic              hit_id;
        logic [SLOT_W-1:0] id_idx;
        logic              hit_empty;
        logic [SLOT_W-1:0] empty_idx;
    } scan_res_t;

    // Reported slot number: low bits of the slot index
    function automatic logic [IDX_OUT_W-1:0] slot_to_out(input logic [SLOT_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[IDX_OUT_W-1:0];
    endfunction

endpackage

FILE: rtl/core/cidwl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cidwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/cidwl_scan.sv
// Shared compare unit: tracks lowest identifier match and lowest empty slot.
`timescale 1ns / 1ps

module cidwl_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          cmp_en,
    input  logic [cidwl_pkg::SLOT_W-1:0]  cmp_idx,
    input  logic [cidwl_pkg::ID_W-1:0]    entry,
    input  logic [cidwl_pkg::ID_W-1:0]    card_id,
    output cidwl_pkg::scan_res_t          res
);
    import cidwl_pkg::*;

    scan_res_t res_reg;
    scan_res_t res_next;
    logic      eq_id;
    logic      eq_empty;

    assign eq_id    = (entry == card_id);
    assign eq_empty = (entry == EMPTY_ID);

    always_comb begin
        res_next = res_reg;
        if (start) begin
            res_next = '0;
        end else if (cmp_en) begin
            if (eq_id && !res_reg.hit_id) begin
                res_next.hit_id = 1'b1;
                res_next.id_idx = cmp_idx;
            end
            if (eq_empty && !res_reg.hit_empty) begin
                res_next.hit_empty = 1'b1;
                res_next.empty_idx = cmp_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= '0;
        end else begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: rtl/core/card_id_whitelist_table.sv
// Top level of the card identifier whitelist table.
`timescale 1ns / 1ps

// Card identifier whitelist table. Holds SLOT_COUNT (32) identifiers of 32
// bits in a RAM; an all-ones entry is an empty slot. Each request carries an
// operation (verify, add, delete, clear all) and an identifier and gets one
// response with a status, the slot matched or written, and a write-back flag
// that mirrors single-slot changes for a persistent store. Verify, add and
// delete read the whole table through one RAM read port and one shared
// compare unit, one slot per cycle, and ready stays low until the response
// has been loaded into the output register, so one request is in flight at
// a time. Clear all skips the scan. Per-slot valid bits, cleared at once by
// reset or by clear all, make the table read as all empty without a clearing
// pass. The response sits in an output register, so the next request is
// taken while an earlier response still waits.
module card_id_whitelist_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] func, [33:2] card_id, [39:34] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [6:2] slot_index,
                                   // [7] slot_valid, [8] write_back, [15:9] zero
);
    import cidwl_pkg::*;

    // Result of the decide step
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] idx;
        logic              slot_valid;
        logic              write_back;
        logic              set_valid;   // add wrote a new entry
        logic              clr_valid;   // delete emptied an entry
    } decide_t;

    state_t state_reg;
    state_t state_next;

    logic                s_accept;
    logic                scan_issue;
    logic                decide_en;
    logic                resp_load;

    logic [FUNC_W-1:0]   func_reg;
    logic [ID_W-1:0]     id_reg;
    logic [CNT_W-1:0]    addr_reg;
    logic [SLOT_W-1:0]   rd_idx;
    logic                last_addr;

    logic [SLOT_COUNT-1:0] valid_reg;
    logic                rd_vld_reg;
    logic                cmp_en_reg;
    logic [SLOT_W-1:0]   cmp_idx_reg;
    logic [ID_W-1:0]     ram_rdata;
    logic [ID_W-1:0]     entry;
    logic                ram_we;

    scan_res_t           scan_res;
    decide_t             dec;

    // Response held between decide and output register
    logic [STAT_W-1:0]    res_status_reg;
    logic [IDX_OUT_W-1:0] res_idx_reg;
    logic                 res_valid_reg;
    logic                 res_wb_reg;

    logic                 m_tvalid_reg;
    logic [STAT_W-1:0]    m_status_reg;
    logic [IDX_OUT_W-1:0] m_idx_reg;
    logic                 m_slot_valid_reg;
    logic                 m_wb_reg;

    assign rd_idx    = addr_reg[SLOT_W-1:0];
    assign last_addr = (addr_reg == CNT_W'(SLOT_COUNT - 1));
    assign s_accept  = s_tvalid && s_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tdata[1:0] == OP_CLEAR) ? S_RESP : S_SCAN;
                end
            end
            S_SCAN: begin
                if (last_addr) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_DECIDE;
            S_DECIDE: state_next = S_RESP;
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_tready   = 1'b0;
        scan_issue = 1'b0;
        decide_en  = 1'b0;
        resp_load  = 1'b0;
        case (state_reg)
            S_IDLE:   s_tready   = 1'b1;
            S_SCAN:   scan_issue = 1'b1;
            S_DECIDE: decide_en  = 1'b1;
            S_RESP:   resp_load  = !m_tvalid_reg || m_tready;
            default: begin
            end
        endcase
    end

    // Table storage; never-written or emptied slots read as empty via valid bits
    cidwl_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (dec.idx),
        .wdata (id_reg),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    assign entry = rd_vld_reg ? ram_rdata : EMPTY_ID;

    cidwl_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .cmp_en  (cmp_en_reg),
        .cmp_idx (cmp_idx_reg),
        .entry   (entry),
        .card_id (id_reg),
        .res     (scan_res)
    );

    // Operation outcome from the scan
    always_comb begin
        dec = '0;
        case (func_reg)
            OP_VERIFY: begin
                if (scan_res.hit_id) begin
                    dec.idx        = scan_res.id_idx;
                    dec.slot_valid = 1'b1;
                end else begin
                    dec.status = STAT_NO_CARD;
                end
            end
            OP_ADD: begin
                if (scan_res.hit_id) begin
                    dec.idx        = scan_res.id_idx;
                    dec.slot_valid = 1'b1;
                end else if (scan_res.hit_empty) begin
                    dec.idx        = scan_res.empty_idx;
                    dec.slot_valid = 1'b1;
                    dec.write_back = 1'b1;
                    dec.set_valid  = 1'b1;
                end else begin
                    dec.status = STAT_NO_MEM;
                end
            end
            OP_DELETE: begin
                if (scan_res.hit_id) begin
                    dec.idx        = scan_res.id_idx;
                    dec.slot_valid = 1'b1;
                    dec.write_back = 1'b1;
                    dec.clr_valid  = 1'b1;
                end else begin
                    dec.status = STAT_NO_CARD;
                end
            end
            default: begin
            end
        endcase
    end

    assign ram_we = decide_en && dec.set_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            cmp_en_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            addr_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            cmp_en_reg  <= scan_issue;
            cmp_idx_reg <= rd_idx;
            rd_vld_reg  <= valid_reg[rd_idx];

            if (s_accept) begin
                func_reg <= s_tdata[1:0];
                id_reg   <= s_tdata[33:2];
                addr_reg <= '0;
                // clear all answers ok with nothing reported
                res_status_reg <= STAT_OK;
                res_idx_reg    <= '0;
                res_valid_reg  <= 1'b0;
                res_wb_reg     <= 1'b0;
                if (s_tdata[1:0] == OP_CLEAR) begin
                    valid_reg <= '0;
                end
            end else if (scan_issue) begin
                addr_reg <= addr_reg + CNT_W'(1);
            end

            if (decide_en) begin
                res_status_reg <= dec.status;
                res_idx_reg    <= dec.slot_valid ? slot_to_out(dec.idx) : '0;
                res_valid_reg  <= dec.slot_valid;
                res_wb_reg     <= dec.write_back;
                if (dec.set_valid) begin
                    valid_reg[dec.idx] <= 1'b1;
                end
                if (dec.clr_valid) begin
                    valid_reg[dec.idx] <= 1'b0;
                end
            end

            if (resp_load) begin
                m_tvalid_reg     <= 1'b1;
                m_status_reg     <= res_status_reg;
                m_idx_reg        <= res_idx_reg;
                m_slot_valid_reg <= res_valid_reg;
                m_wb_reg         <= res_wb_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_wb_reg, m_slot_valid_reg, m_idx_reg, m_status_reg};

    // Write-back only ever accompanies a reported slot
    a_wb_has_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[8] || m_tdata[7]))
        else $error("write_back without slot_valid");

    // A failed request reports no slot
    a_fail_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] != STAT_OK)) |-> (m_tdata[7:2] == 6'd0))
        else $error("slot reported on failed request");

    // Table written only in the decide step
    a_we_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_DECIDE))
        else $error("table write outside decide");

    // One request at a time
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("request taken while busy");

endmodule

FILE: bench/tb.sv
// Testbench for card_id_whitelist_table: predicts each response and checks it.
`timescale 1ns / 1ps

module tb;
    import cidwl_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int POOL_SIZE   = 48;
    localparam int TAIL_CYCLES = 50;   // a bit over one full table scan

    // Expected response, one field per output field
    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [IDX_OUT_W-1:0] slot_index;
        logic                 slot_valid;
        logic                 write_back;
    } resp_t;

    // Mirror of the card table plus the queue of responses still owed.
    class whitelist_tracker;
        logic [ID_W-1:0] mirror_table [SLOT_COUNT];
        resp_t           owed_resp [$];
        int              mismatches;

        function new();
            mismatches = 0;
            wipe_table();
        endfunction

        function void wipe_table();
            foreach (mirror_table[i]) mirror_table[i] = EMPTY_ID;
        endfunction

        // Lowest slot holding id, or -1
        function int lowest_match(logic [ID_W-1:0] id);
            for (int i = 0; i < SLOT_COUNT; i++)
                if (mirror_table[i] == id) return i;
            return -1;
        endfunction

        // Applies one request to the mirror and returns the response it earns
        function resp_t apply_request(logic [FUNC_W-1:0] op, logic [ID_W-1:0] id);
            resp_t r;
            int    hit;
            int    spare;
            r   = '0;
            hit = lowest_match(id);
            case (op)
                OP_VERIFY: begin
                    if (hit >= 0) begin
                        r.slot_valid = 1'b1;
                        r.slot_index = IDX_OUT_W'(hit);
                    end else begin
                        r.status = STAT_NO_CARD;
                    end
                end
                OP_ADD: begin
                    if (hit >= 0) begin
                        r.slot_valid = 1'b1;
                        r.slot_index = IDX_OUT_W'(hit);
                    end else begin
                        spare = lowest_match(EMPTY_ID);
                        if (spare >= 0) begin
                            mirror_table[spare] = id;
                            r.slot_valid = 1'b1;
                            r.write_back = 1'b1;
                            r.slot_index = IDX_OUT_W'(spare);
                        end else begin
                            r.status = STAT_NO_MEM;
                        end
                    end
                end
                OP_DELETE: begin
                    if (hit >= 0) begin
                        mirror_table[hit] = EMPTY_ID;
                        r.slot_valid = 1'b1;
                        r.write_back = 1'b1;
                        r.slot_index = IDX_OUT_W'(hit);
                    end else begin
                        r.status = STAT_NO_CARD;
                    end
                end
                default: begin
                    wipe_table();
                end
            endcase
            return r;
        endfunction

        function void note_request(logic [FUNC_W-1:0] op, logic [ID_W-1:0] id);
            owed_resp.push_back(apply_request(op, id));
        endfunction

        function void check_response(logic [15:0] word);
            resp_t got;
            resp_t want;
            got.status     = word[1:0];
            got.slot_index = word[6:2];
            got.slot_valid = word[7];
            got.write_back = word[8];
            if (owed_resp.size() == 0) begin
                $display("%0t: unexpected response, expected none, actual %h", $time, word);
                mismatches++;
                return;
            end
            want = owed_resp.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
            if (got.slot_index !== want.slot_index) begin
                $display("%0t: slot_index expected %0d actual %0d",
                         $time, want.slot_index, got.slot_index);
                mismatches++;
            end
            if (got.slot_valid !== want.slot_valid) begin
                $display("%0t: slot_valid expected %0d actual %0d",
                         $time, want.slot_valid, got.slot_valid);
                mismatches++;
            end
            if (got.write_back !== want.write_back) begin
                $display("%0t: write_back expected %0d actual %0d",
                         $time, want.write_back, got.write_back);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return owed_resp.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // [1:0] func, [33:2] card_id, [39:34] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [1:0] status, [6:2] slot_index, [7] slot_valid,
                             // [8] write_back, [15:9] zero

    whitelist_tracker book = new();
    logic [ID_W-1:0]  id_pool [POOL_SIZE];
    bit               calm;  // when set, neither side inserts gaps
    int               cycles;

    card_id_whitelist_table uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 0;
    end

    // Mostly back to back, some short gaps, a few long ones
    function int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // One request: optional idle gap, then hold valid until the handshake.
    // Valid is driven once per step, so back-to-back requests never glitch it.
    task automatic send_req(logic [FUNC_W-1:0] op, logic [ID_W-1:0] id);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, id, op};
        do @(posedge aclk); while (!s_tready);
        book.note_request(op, id);
    endtask

    // Sender hold-off until every owed response has come back; valid drops
    // so the last request is not taken again
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (book.outstanding() != 0) @(posedge aclk);
    endtask

    // Corners on a near-empty table, including the all-ones identifier
    // that matches an empty slot.
    task automatic run_directed();
        send_req(OP_VERIFY, 32'h0000_0000);   // miss on empty table
        send_req(OP_VERIFY, EMPTY_ID);        // all ones hits slot 0
        send_req(OP_ADD,    EMPTY_ID);        // hit, nothing written
        send_req(OP_DELETE, EMPTY_ID);        // rewrites slot 0, write-back set
        send_req(OP_ADD,    32'h0000_0000);
        send_req(OP_ADD,    32'h0000_0000);   // already present
        send_req(OP_ADD,    32'hFFFF_FFFE);
        send_req(OP_ADD,    32'h8000_0001);
        send_req(OP_VERIFY, 32'h8000_0001);
        send_req(OP_DELETE, 32'h0000_0000);
        send_req(OP_DELETE, 32'h0000_0000);   // miss on delete
        send_req(OP_ADD,    32'h1234_5678);   // reuses the freed slot 0
        send_req(OP_VERIFY, 32'hFFFF_FFFE);
        send_req(OP_CLEAR,  32'hA5A5_A5A5);
        send_req(OP_VERIFY, 32'hFFFF_FFFE);   // gone after clear
        send_req(OP_DELETE, EMPTY_ID);
        send_req(OP_CLEAR,  EMPTY_ID);
    endtask

    // Fill every slot, then hit the full-table cases
    task automatic run_fill();
        send_req(OP_CLEAR, 32'h0);
        for (int k = 0; k < SLOT_COUNT; k++) send_req(OP_ADD, id_pool[k]);
        send_req(OP_ADD,    id_pool[40]);     // table full
        send_req(OP_VERIFY, EMPTY_ID);        // no empty slot left
        send_req(OP_DELETE, EMPTY_ID);
        send_req(OP_ADD,    EMPTY_ID);        // full, all ones
        send_req(OP_VERIFY, id_pool[SLOT_COUNT-1]);
        send_req(OP_DELETE, id_pool[7]);
        send_req(OP_ADD,    EMPTY_ID);        // hits the hole at slot 7
        send_req(OP_ADD,    id_pool[41]);     // fills slot 7
    endtask

    // Mostly pool identifiers so hits, fills and deletes happen; some noise,
    // some all-ones, rare clears. Adds outweigh deletes so the table fills.
    task automatic run_random(int count);
        int              r;
        logic [FUNC_W-1:0] op;
        logic [ID_W-1:0]   id;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                op = OP_CLEAR;
                id = $urandom;
            end else if (r < 8) begin
                op = FUNC_W'($urandom_range(0, 2));
                id = EMPTY_ID;
            end else if (r < 15) begin
                op = FUNC_W'($urandom_range(0, 2));
                id = $urandom;
            end else begin
                id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
                r  = $urandom_range(0, 99);
                op = (r < 45) ? OP_ADD : (r < 75) ? OP_VERIFY : OP_DELETE;
            end
            send_req(op, id);
        end
    endtask

    // Response sink: ready dropped for random stretches, any phase
    initial begin
        int hold;
        wait (aresetn);
        forever begin
            hold = pick_gap();
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    // Response check on each accepted response
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.check_response(m_tdata);
    end

    // Run limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("** card_id_whitelist_table: FAILED **");
        $finish;
    end

    initial begin
        logic [31:0] seed_bits;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        calm     = 1'b0;
        // Distinct pool ids: random upper bits, index in the low six bits,
        // so none is all ones
        for (int k = 0; k < POOL_SIZE; k++) begin
            seed_bits  = $urandom;
            id_pool[k] = {seed_bits[31:6], 6'(k)};
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        wait_drained();
        run_fill();
        wait_drained();
        run_random(170);
        wait_drained();
        calm = 1'b1;            // a stretch with no idling on either side
        run_random(160);
        calm = 1'b0;
        wait_drained();
        run_random(330);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (book.mismatches == 0 && book.outstanding() == 0) begin
            $display("** card_id_whitelist_table: PASSED **");
        end else begin
            $display("** card_id_whitelist_table: FAILED **");
        end
        $finish;
    end

endmodule
